[src/mrmp_pkg.sv]
package mrmp_pkg;

	typedef logic [5:0] src_t;

	localparam src_t SRC_E    = 6'd32;
	localparam src_t SRC_G    = 6'd33;
	localparam src_t SRC_Y0   = 6'd34;
	localparam src_t SRC_H    = 6'd35;
	localparam src_t SRC_ONE  = 6'd36;
	localparam src_t SRC_ZERO = 6'd37;
	localparam src_t SRC_IN0  = 6'd38;
	localparam src_t SRC_IN1  = 6'd39;
	localparam src_t SRC_IN2  = 6'd40;
	localparam src_t SRC_IN3  = 6'd41;
	localparam src_t SRC_IN4  = 6'd42;
	localparam src_t SRC_IN5  = 6'd43;
	localparam src_t SRC_EQP0 = 6'd44;
	localparam src_t SRC_GST  = 6'd45;

	localparam logic [1:0] CAP_GAMMA = 2'd0;
	localparam logic [1:0] CAP_N0    = 2'd1;
	localparam logic [1:0] CAP_N1    = 2'd2;
	localparam logic [1:0] CAP_N2    = 2'd3;

	localparam logic [2:0] REG_YOUNG = 3'd0;
	localparam logic [2:0] REG_SHEAR = 3'd1;
	localparam logic [2:0] REG_YIELD = 3'd2;
	localparam logic [2:0] REG_HARD  = 3'd3;
	localparam logic [2:0] REG_PLAST = 3'd4;
	localparam logic [2:0] REG_MAXIT = 3'd5;

	localparam logic [63:0] TOL_INVERSE = 64'd1000000;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_TRIPLE, OP_POS, OP_MUL, OP_SQ1, OP_SQ3,
		OP_CONV, OP_DIV, OP_NDIV, OP_SQRT
	} op_t;

	typedef struct packed {
		logic       start;
		logic       load;
		op_t        op;
		src_t       a;
		src_t       b;
		logic [4:0] d;
		logic       cap_en;
		logic [1:0] cap_sel;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic flag;
		logic busy;
	} dp_stat_t;

	typedef struct packed {
		logic       publish;
		logic       yielding;
		logic       unconv;
		logic [7:0] iters;
	} res_stat_t;

	typedef struct packed {
		logic [62:0] young;
		logic [62:0] shear;
		logic [62:0] yield0;
		logic [62:0] hard;
	} cfg_t;

	typedef struct packed {
		logic [63:0] gstart;
		logic [62:0] eqp;
		logic [63:0] pl2;
		logic [63:0] pl1;
		logic [63:0] pl0;
		logic [63:0] st2;
		logic [63:0] st1;
		logic [63:0] st0;
	} in_t;

endpackage

[src/mrmp_ctrl.sv]
module mrmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_busy,
	input  logic                plast_en,
	input  logic [7:0]          max_iter,
	input  mrmp_pkg::dp_stat_t  stat,
	output mrmp_pkg::cmd_t      cmd,
	output mrmp_pkg::res_stat_t res
);

	localparam mrmp_pkg::src_t R_ET0 = 6'd0;
	localparam mrmp_pkg::src_t R_ET1 = 6'd1;
	localparam mrmp_pkg::src_t R_ET2 = 6'd2;
	localparam mrmp_pkg::src_t R_PC  = 6'd3;
	localparam mrmp_pkg::src_t R_ST0 = 6'd4;
	localparam mrmp_pkg::src_t R_ST1 = 6'd5;
	localparam mrmp_pkg::src_t R_ST2 = 6'd6;
	localparam mrmp_pkg::src_t R_EQS = 6'd7;
	localparam mrmp_pkg::src_t R_SY  = 6'd8;
	localparam mrmp_pkg::src_t R_EQP = 6'd9;
	localparam mrmp_pkg::src_t R_T0  = 6'd10;
	localparam mrmp_pkg::src_t R_T1  = 6'd11;
	localparam mrmp_pkg::src_t R_BC0 = 6'd12;
	localparam mrmp_pkg::src_t R_BC1 = 6'd13;
	localparam mrmp_pkg::src_t R_N0  = 6'd15;
	localparam mrmp_pkg::src_t R_N1  = 6'd16;
	localparam mrmp_pkg::src_t R_N2  = 6'd17;
	localparam mrmp_pkg::src_t R_Q   = 6'd18;
	localparam mrmp_pkg::src_t R_R1  = 6'd19;
	localparam mrmp_pkg::src_t R_R2  = 6'd20;
	localparam mrmp_pkg::src_t R_DF  = 6'd21;
	localparam mrmp_pkg::src_t R_F   = 6'd22;
	localparam mrmp_pkg::src_t R_NG  = 6'd23;
	localparam mrmp_pkg::src_t R_GAM = 6'd24;
	localparam mrmp_pkg::src_t R_FT  = 6'd25;
	localparam mrmp_pkg::src_t R_NUL = 6'd26;

	localparam logic [6:0] ST_TEST  = 7'd14;
	localparam logic [6:0] ST_LOOP  = 7'd16;
	localparam logic [6:0] ST_CONV  = 7'd58;
	localparam logic [6:0] ST_ITEND = 7'd59;
	localparam logic [6:0] ST_FINAL = 7'd60;
	localparam logic [6:0] ST_END   = 7'd69;

	typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_START, S_WAIT, S_FIN} state_t;

	state_t     state_q;
	logic [6:0] step_q;
	logic       yld_q;
	logic       unconv_q;
	logic [7:0] iters_q;
	logic [7:0] limit;

	function automatic mrmp_pkg::cmd_t mk(mrmp_pkg::op_t op, mrmp_pkg::src_t a,
			mrmp_pkg::src_t b, mrmp_pkg::src_t d);
		mrmp_pkg::cmd_t c;
		c = '0;
		c.op = op;
		c.a = a;
		c.b = b;
		c.d = d[4:0];
		return c;
	endfunction

	function automatic mrmp_pkg::cmd_t mkc(mrmp_pkg::op_t op, mrmp_pkg::src_t a,
			mrmp_pkg::src_t b, mrmp_pkg::src_t d, logic [1:0] cap);
		mrmp_pkg::cmd_t c;
		c = mk(op, a, b, d);
		c.cap_en = 1'b1;
		c.cap_sel = cap;
		return c;
	endfunction

	function automatic mrmp_pkg::cmd_t prog(logic [6:0] s, logic yld);
		mrmp_pkg::cmd_t c;
		case (s)
			7'd0:  c = mk(mrmp_pkg::OP_SUB, mrmp_pkg::SRC_IN0, mrmp_pkg::SRC_IN3, R_ET0);
			7'd1:  c = mk(mrmp_pkg::OP_SUB, mrmp_pkg::SRC_IN1, mrmp_pkg::SRC_IN4, R_ET1);
			7'd2:  c = mk(mrmp_pkg::OP_SUB, mrmp_pkg::SRC_IN2, mrmp_pkg::SRC_IN5, R_ET2);
			7'd3:  c = mk(mrmp_pkg::OP_TRIPLE, mrmp_pkg::SRC_G, mrmp_pkg::SRC_ZERO, R_PC);
			7'd4:  c = mk(mrmp_pkg::OP_MUL, mrmp_pkg::SRC_E, R_ET0, R_ST0);
			7'd5:  c = mk(mrmp_pkg::OP_MUL, mrmp_pkg::SRC_G, R_ET1, R_ST1);
			7'd6:  c = mk(mrmp_pkg::OP_MUL, mrmp_pkg::SRC_G, R_ET2, R_ST2);
			7'd7:  c = mk(mrmp_pkg::OP_SQ1, R_ST0, R_ST0, R_NUL);
			7'd8:  c = mk(mrmp_pkg::OP_SQ3, R_ST1, R_ST1, R_NUL);
			7'd9:  c = mk(mrmp_pkg::OP_SQ3, R_ST2, R_ST2, R_NUL);
			7'd10: c = mk(mrmp_pkg::OP_SQRT, R_NUL, R_NUL, R_EQS);
			7'd11: c = mk(mrmp_pkg::OP_MUL, mrmp_pkg::SRC_H, mrmp_pkg::SRC_EQP0, R_T0);
			7'd12: c = mk(mrmp_pkg::OP_ADD, mrmp_pkg::SRC_Y0, R_T0, R_T0);
			7'd13: c = mk(mrmp_pkg::OP_SUB, R_EQS, R_T0, R_FT);
			7'd14: c = mk(mrmp_pkg::OP_POS, R_FT, R_FT, R_NUL);
			7'd15: c = mk(mrmp_pkg::OP_ADD, mrmp_pkg::SRC_GST, mrmp_pkg::SRC_ZERO, R_GAM);
			7'd16: c = mk(mrmp_pkg::OP_ADD, mrmp_pkg::SRC_EQP0, R_GAM, R_EQP);
			7'd17: c = mk(mrmp_pkg::OP_MUL, mrmp_pkg::SRC_H, R_EQP, R_T0);
			7'd18: c = mk(mrmp_pkg::OP_ADD, mrmp_pkg::SRC_Y0, R_T0, R_SY);
			7'd19: c = mk(mrmp_pkg::OP_MUL, mrmp_pkg::SRC_E, R_GAM, R_T0);
			7'd20: c = mk(mrmp_pkg::OP_DIV, R_T0, R_SY, R_T0);
			7'd21: c = mk(mrmp_pkg::OP_ADD, mrmp_pkg::SRC_ONE, R_T0, R_T0);
			7'd22: c = mk(mrmp_pkg::OP_DIV, mrmp_pkg::SRC_E, R_T0, R_BC0);
			7'd23: c = mk(mrmp_pkg::OP_MUL, R_PC, R_GAM, R_T0);
			7'd24: c = mk(mrmp_pkg::OP_DIV, R_T0, R_SY, R_T0);
			7'd25: c = mk(mrmp_pkg::OP_ADD, mrmp_pkg::SRC_ONE, R_T0, R_T0);
			7'd26: c = mk(mrmp_pkg::OP_DIV, mrmp_pkg::SRC_G, R_T0, R_BC1);
			7'd27: c = mk(mrmp_pkg::OP_MUL, R_BC0, R_ET0, R_ST0);
			7'd28: c = mk(mrmp_pkg::OP_MUL, R_BC1, R_ET1, R_ST1);
			7'd29: c = mk(mrmp_pkg::OP_MUL, R_BC1, R_ET2, R_ST2);
			7'd30: c = mk(mrmp_pkg::OP_SQ1, R_ST0, R_ST0, R_NUL);
			7'd31: c = mk(mrmp_pkg::OP_SQ3, R_ST1, R_ST1, R_NUL);
			7'd32: c = mk(mrmp_pkg::OP_SQ3, R_ST2, R_ST2, R_NUL);
			7'd33: c = mk(mrmp_pkg::OP_SQRT, R_NUL, R_NUL, R_EQS);
			7'd34: c = mk(mrmp_pkg::OP_SUB, R_EQS, R_SY, R_F);
			7'd35: c = mk(mrmp_pkg::OP_NDIV, R_ST0, R_EQS, R_N0);
			7'd36: c = mk(mrmp_pkg::OP_TRIPLE, R_ST1, R_ST1, R_T1);
			7'd37: c = mk(mrmp_pkg::OP_NDIV, R_T1, R_EQS, R_N1);
			7'd38: c = mk(mrmp_pkg::OP_TRIPLE, R_ST2, R_ST2, R_T1);
			7'd39: c = mk(mrmp_pkg::OP_NDIV, R_T1, R_EQS, R_N2);
			7'd40: c = mk(mrmp_pkg::OP_MUL, R_N0, R_N0, R_T0);
			7'd41: c = mk(mrmp_pkg::OP_MUL, R_BC0, R_T0, R_Q);
			7'd42: c = mk(mrmp_pkg::OP_MUL, R_N1, R_N1, R_T0);
			7'd43: c = mk(mrmp_pkg::OP_MUL, R_BC1, R_T0, R_T0);
			7'd44: c = mk(mrmp_pkg::OP_ADD, R_Q, R_T0, R_Q);
			7'd45: c = mk(mrmp_pkg::OP_MUL, R_N2, R_N2, R_T0);
			7'd46: c = mk(mrmp_pkg::OP_MUL, R_BC1, R_T0, R_T0);
			7'd47: c = mk(mrmp_pkg::OP_ADD, R_Q, R_T0, R_Q);
			7'd48: c = mk(mrmp_pkg::OP_DIV, R_EQS, R_SY, R_R1);
			7'd49: c = mk(mrmp_pkg::OP_MUL, R_GAM, mrmp_pkg::SRC_H, R_T0);
			7'd50: c = mk(mrmp_pkg::OP_DIV, R_T0, R_SY, R_T0);
			7'd51: c = mk(mrmp_pkg::OP_SUB, mrmp_pkg::SRC_ONE, R_T0, R_R2);
			7'd52: c = mk(mrmp_pkg::OP_MUL, R_R1, R_R2, R_T0);
			7'd53: c = mk(mrmp_pkg::OP_MUL, R_T0, R_Q, R_T0);
			7'd54: c = mk(mrmp_pkg::OP_ADD, R_T0, mrmp_pkg::SRC_H, R_T0);
			7'd55: c = mk(mrmp_pkg::OP_SUB, mrmp_pkg::SRC_ZERO, R_T0, R_DF);
			7'd56: c = mk(mrmp_pkg::OP_DIV, R_F, R_DF, R_T0);
			7'd57: c = mk(mrmp_pkg::OP_SUB, R_GAM, R_T0, R_NG);
			7'd58: c = mk(mrmp_pkg::OP_CONV, R_NG, R_GAM, R_NUL);
			7'd59: c = mk(mrmp_pkg::OP_ADD, R_NG, mrmp_pkg::SRC_ZERO, R_GAM);
			7'd60: c = mk(mrmp_pkg::OP_SQ1, R_ST0, R_ST0, R_NUL);
			7'd61: c = mk(mrmp_pkg::OP_SQ3, R_ST1, R_ST1, R_NUL);
			7'd62: c = mk(mrmp_pkg::OP_SQ3, R_ST2, R_ST2, R_NUL);
			7'd63: c = mk(mrmp_pkg::OP_SQRT, R_NUL, R_NUL, R_EQS);
			7'd64: c = mkc(mrmp_pkg::OP_NDIV, R_ST0, R_EQS, R_N0, mrmp_pkg::CAP_N0);
			7'd65: c = mk(mrmp_pkg::OP_TRIPLE, R_ST1, R_ST1, R_T1);
			7'd66: c = mkc(mrmp_pkg::OP_NDIV, R_T1, R_EQS, R_N1, mrmp_pkg::CAP_N1);
			7'd67: c = mk(mrmp_pkg::OP_TRIPLE, R_ST2, R_ST2, R_T1);
			7'd68: c = mkc(mrmp_pkg::OP_NDIV, R_T1, R_EQS, R_N2, mrmp_pkg::CAP_N2);
			7'd69: c = mkc(mrmp_pkg::OP_ADD, yld ? R_GAM : mrmp_pkg::SRC_ZERO,
				mrmp_pkg::SRC_ZERO, R_T0, mrmp_pkg::CAP_GAMMA);
			default: c = mk(mrmp_pkg::OP_ADD, mrmp_pkg::SRC_ZERO, mrmp_pkg::SRC_ZERO, R_NUL);
		endcase
		return c;
	endfunction

	assign limit = (max_iter == 8'd0) ? 8'd1 : max_iter;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			yld_q    <= 1'b0;
			unconv_q <= 1'b0;
			iters_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q   <= '0;
						yld_q    <= 1'b0;
						unconv_q <= 1'b0;
						iters_q  <= '0;
						state_q  <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (stat.done) begin
						state_q <= S_ISSUE;
						case (step_q)
							ST_TEST: begin
								if (stat.flag && plast_en) begin
									yld_q  <= 1'b1;
									step_q <= step_q + 7'd1;
								end else begin
									step_q <= ST_FINAL;
								end
							end
							ST_CONV: begin
								unconv_q <= stat.flag;
								step_q   <= step_q + 7'd1;
							end
							ST_ITEND: begin
								iters_q <= iters_q + 8'd1;
								if (unconv_q && ({1'b0, iters_q} + 9'd1 < {1'b0, limit}))
									step_q <= ST_LOOP;
								else
									step_q <= ST_FINAL;
							end
							ST_END: state_q <= S_FIN;
							default: step_q <= step_q + 7'd1;
						endcase
					end
				end
				S_FIN: begin
					if (!out_busy)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = prog(step_q, yld_q);
		cmd.start = (state_q == S_START);
		cmd.load = (state_q == S_IDLE) && in_valid;
	end

	assign res.publish  = (state_q == S_FIN) && !out_busy;
	assign res.yielding = yld_q;
	assign res.unconv   = unconv_q;
	assign res.iters    = iters_q;

endmodule

[src/mrmp_dpath.sv]
module mrmp_dpath #(
	parameter int FRAC_BITS = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mrmp_pkg::cmd_t     cmd,
	input  mrmp_pkg::in_t      din,
	input  mrmp_pkg::cfg_t     cfg,
	output mrmp_pkg::dp_stat_t stat,
	output logic [63:0]        res_gamma,
	output logic [63:0]        res_n0,
	output logic [63:0]        res_n1,
	output logic [63:0]        res_n2
);

	localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;

	logic [63:0]  rf [0:31];
	logic [63:0]  rda_q, rdb_q;
	mrmp_pkg::in_t in_q;
	logic [63:0]  res_q [0:3];

	mrmp_pkg::op_t op_q;
	logic [4:0]   d_q;
	logic         cap_en_q;
	logic [1:0]   cap_sel_q;
	logic         busy_q, done_q, flag_q;
	logic [7:0]   cnt_q;
	logic [63:0]  a_q, b_q, ma_q, mb_q;
	logic [127:0] acc_q, sum_q, num_q, quo_q, rad_q;
	logic [63:0]  rem_q, root_q;
	logic [65:0]  srem_q;

	logic [63:0]  opa, opb, res_w, ah, bh, pp;
	logic [6:0]   shamt;
	logic         fin, wen;
	logic [64:0]  drr;
	logic [67:0]  srm, strial;
	logic [130:0] sum3;

	function automatic logic [63:0] mag(logic [63:0] a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic [63:0] from_mag(logic neg, logic [127:0] m);
		if (m[127:63] != '0)
			return neg ? SMIN : SMAX;
		return neg ? (~m[63:0] + 64'd1) : m[63:0];
	endfunction

	function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] ssub(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] triple(logic [63:0] a);
		logic [65:0] t;
		t = {{2{a[63]}}, a} + {a[63], a, 1'b0};
		if (!(t[65:63] == 3'b000 || t[65:63] == 3'b111))
			return t[65] ? SMIN : SMAX;
		return t[63:0];
	endfunction

	function automatic logic [63:0] operand(mrmp_pkg::src_t s, logic [63:0] rd,
			mrmp_pkg::in_t i, mrmp_pkg::cfg_t c);
		if (!s[5])
			return rd;
		case (s)
			mrmp_pkg::SRC_E:    return {1'b0, c.young};
			mrmp_pkg::SRC_G:    return {1'b0, c.shear};
			mrmp_pkg::SRC_Y0:   return {1'b0, c.yield0};
			mrmp_pkg::SRC_H:    return {1'b0, c.hard};
			mrmp_pkg::SRC_ONE:  return ONE;
			mrmp_pkg::SRC_IN0:  return i.st0;
			mrmp_pkg::SRC_IN1:  return i.st1;
			mrmp_pkg::SRC_IN2:  return i.st2;
			mrmp_pkg::SRC_IN3:  return i.pl0;
			mrmp_pkg::SRC_IN4:  return i.pl1;
			mrmp_pkg::SRC_IN5:  return i.pl2;
			mrmp_pkg::SRC_EQP0: return {1'b0, i.eqp};
			mrmp_pkg::SRC_GST:  return i.gstart;
			default:            return 64'd0;
		endcase
	endfunction

	assign opa = operand(cmd.a, rda_q, in_q, cfg);
	assign opb = operand(cmd.b, rdb_q, in_q, cfg);

	assign ah    = cnt_q[0] ? {32'd0, ma_q[63:32]} : {32'd0, ma_q[31:0]};
	assign bh    = cnt_q[1] ? {32'd0, mb_q[63:32]} : {32'd0, mb_q[31:0]};
	assign pp    = {32'd0, ah[31:0]} * {32'd0, bh[31:0]};
	assign shamt = {({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]}), 5'd0};

	assign drr    = {rem_q, num_q[127]};
	assign srm    = {srem_q, rad_q[127:126]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sum3   = {3'b000, sum_q} + {2'b00, acc_q, 1'b0} + {3'b000, acc_q};

	always_comb begin
		fin = 1'b0;
		wen = 1'b0;
		res_w = 64'd0;
		case (op_q)
			mrmp_pkg::OP_ADD: begin
				fin = 1'b1; wen = 1'b1; res_w = sadd(a_q, b_q);
			end
			mrmp_pkg::OP_SUB: begin
				fin = 1'b1; wen = 1'b1; res_w = ssub(a_q, b_q);
			end
			mrmp_pkg::OP_TRIPLE: begin
				fin = 1'b1; wen = 1'b1; res_w = triple(a_q);
			end
			mrmp_pkg::OP_POS: fin = 1'b1;
			mrmp_pkg::OP_MUL: begin
				fin = (cnt_q == 8'd4); wen = 1'b1;
				res_w = from_mag(a_q[63] ^ b_q[63], acc_q >> FRAC_BITS);
			end
			mrmp_pkg::OP_SQ1, mrmp_pkg::OP_SQ3, mrmp_pkg::OP_CONV: fin = (cnt_q == 8'd4);
			mrmp_pkg::OP_DIV, mrmp_pkg::OP_NDIV: begin
				fin = (b_q == 64'd0) || (cnt_q == 8'd128);
				wen = 1'b1;
				if (b_q != 64'd0)
					res_w = from_mag(a_q[63] ^ b_q[63], quo_q);
				else if (op_q == mrmp_pkg::OP_NDIV || a_q == 64'd0)
					res_w = 64'd0;
				else
					res_w = a_q[63] ? SMIN : SMAX;
			end
			mrmp_pkg::OP_SQRT: begin
				fin = (cnt_q == 8'd64); wen = 1'b1;
				res_w = root_q[63] ? SMAX : root_q;
			end
			default: fin = 1'b1;
		endcase
		fin = fin && busy_q;
	end

	always_ff @(posedge clk) begin
		rda_q <= rf[cmd.a[4:0]];
		rdb_q <= rf[cmd.b[4:0]];
		if (fin && wen)
			rf[d_q] <= res_w;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= din;
		if (fin && cap_en_q)
			res_q[cap_sel_q] <= res_w;
		if (cmd.start) begin
			a_q       <= opa;
			b_q       <= opb;
			op_q      <= cmd.op;
			d_q       <= cmd.d;
			cap_en_q  <= cmd.cap_en;
			cap_sel_q <= cmd.cap_sel;
			ma_q      <= (cmd.op == mrmp_pkg::OP_CONV) ? mag(ssub(opa, opb)) : mag(opa);
			case (cmd.op)
				mrmp_pkg::OP_CONV:                   mb_q <= mrmp_pkg::TOL_INVERSE;
				mrmp_pkg::OP_SQ1, mrmp_pkg::OP_SQ3: mb_q <= mag(opa);
				default:                             mb_q <= mag(opb);
			endcase
			acc_q  <= '0;
			num_q  <= {64'd0, mag(opa)} << FRAC_BITS;
			quo_q  <= '0;
			rem_q  <= '0;
			rad_q  <= sum_q;
			root_q <= '0;
			srem_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 8'd4)
				acc_q <= acc_q + ({64'd0, pp} << shamt);
			if (cnt_q < 8'd128) begin
				num_q <= {num_q[126:0], 1'b0};
				if (drr >= {1'b0, mb_q}) begin
					rem_q <= 64'(drr - {1'b0, mb_q});
					quo_q <= {quo_q[126:0], 1'b1};
				end else begin
					rem_q <= drr[63:0];
					quo_q <= {quo_q[126:0], 1'b0};
				end
			end
			if (cnt_q < 8'd64) begin
				rad_q <= {rad_q[125:0], 2'b00};
				if (srm >= strial) begin
					srem_q <= 66'(srm - strial);
					root_q <= {root_q[62:0], 1'b1};
				end else begin
					srem_q <= srm[65:0];
					root_q <= {root_q[62:0], 1'b0};
				end
			end
			if (fin) begin
				case (op_q)
					mrmp_pkg::OP_SQ1: sum_q <= acc_q;
					mrmp_pkg::OP_SQ3: sum_q <= (sum3[130:128] != 3'b000) ? '1 : sum3[127:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			flag_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 8'd1;
				if (fin) begin
					busy_q <= 1'b0;
					case (op_q)
						mrmp_pkg::OP_POS:  flag_q <= !a_q[63] && (a_q != 64'd0);
						mrmp_pkg::OP_CONV: flag_q <= acc_q > {64'd0, mag(a_q)};
						default: ;
					endcase
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.flag = flag_q;
	assign stat.busy = busy_q;

	assign res_gamma = res_q[mrmp_pkg::CAP_GAMMA];
	assign res_n0    = res_q[mrmp_pkg::CAP_N0];
	assign res_n1    = res_q[mrmp_pkg::CAP_N1];
	assign res_n2    = res_q[mrmp_pkg::CAP_N2];

endmodule

[src/mises_return_mapping_point.sv]
// One point is in work at a time. The datapath uses a shared bit-serial divider (one
// quotient bit per cycle, ten divisions per Newton iteration for a yielding point) and
// a bit-serial square root (one root bit per cycle).
// A new point is taken while the previous result waits in the output register.
// Reset (arst_n low) restores register defaults and empties the output register.
module mises_return_mapping_point #(
	parameter int FRAC_BITS = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// strain_axial, strain_shear_y, strain_shear_z, plastic_axial, plastic_shear_y,
	// plastic_shear_z, equivalent_plastic (63), gamma_start, one zero pad bit
	input  logic [511:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// gamma_out, normal_axial, normal_shear_y, normal_shear_z, iterations_used
	output logic [263:0] m_tdata,
	// is_yielding, not_converged
	output logic [1:0]   m_tuser
);

	mrmp_pkg::cfg_t      cfg_q;
	logic                plast_q;
	logic [7:0]          maxit_q;
	mrmp_pkg::cmd_t      cmd;
	mrmp_pkg::dp_stat_t  stat;
	mrmp_pkg::res_stat_t res;
	mrmp_pkg::in_t       din;
	logic [63:0]         r_gamma, r_n0, r_n1, r_n2;
	logic                out_valid_q, out_busy, wr;
	logic [263:0]        out_data_q;
	logic [1:0]          out_user_q;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.young  <= 63'd219902325555200000;
			cfg_q.shear  <= 63'd87960930222080000;
			cfg_q.yield0 <= 63'd274877906944000;
			cfg_q.hard   <= 63'd0;
			plast_q      <= 1'b1;
			maxit_q      <= 8'd100;
		end else if (wr) begin
			case (paddr[5:3])
				mrmp_pkg::REG_YOUNG: cfg_q.young  <= pwdata[62:0];
				mrmp_pkg::REG_SHEAR: cfg_q.shear  <= pwdata[62:0];
				mrmp_pkg::REG_YIELD: cfg_q.yield0 <= pwdata[62:0];
				mrmp_pkg::REG_HARD:  cfg_q.hard   <= pwdata[62:0];
				mrmp_pkg::REG_PLAST: plast_q      <= pwdata[0];
				mrmp_pkg::REG_MAXIT: maxit_q      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			mrmp_pkg::REG_YOUNG: prdata = {1'b0, cfg_q.young};
			mrmp_pkg::REG_SHEAR: prdata = {1'b0, cfg_q.shear};
			mrmp_pkg::REG_YIELD: prdata = {1'b0, cfg_q.yield0};
			mrmp_pkg::REG_HARD:  prdata = {1'b0, cfg_q.hard};
			mrmp_pkg::REG_PLAST: prdata = {63'd0, plast_q};
			mrmp_pkg::REG_MAXIT: prdata = {56'd0, maxit_q};
			default:             prdata = 64'd0;
		endcase
	end

	assign din.st0    = s_tdata[63:0];
	assign din.st1    = s_tdata[127:64];
	assign din.st2    = s_tdata[191:128];
	assign din.pl0    = s_tdata[255:192];
	assign din.pl1    = s_tdata[319:256];
	assign din.pl2    = s_tdata[383:320];
	assign din.eqp    = s_tdata[446:384];
	assign din.gstart = s_tdata[510:447];

	assign out_busy = out_valid_q && !m_tready;

	mrmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_busy (out_busy),
		.plast_en (plast_q),
		.max_iter (maxit_q),
		.stat     (stat),
		.cmd      (cmd),
		.res      (res)
	);

	mrmp_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.din       (din),
		.cfg       (cfg_q),
		.stat      (stat),
		.res_gamma (r_gamma),
		.res_n0    (r_n0),
		.res_n1    (r_n1),
		.res_n2    (r_n2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res.publish)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res.publish) begin
			out_data_q <= {res.iters, r_n2, r_n1, r_n0, r_gamma};
			out_user_q <= {res.unconv, res.yielding};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.publish |-> !out_busy)
		else $error("result published over a pending beat");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.busy)
		else $error("input ready while datapath busy");

	a_unconv_yield: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tuser[0])
		else $error("not converged on elastic point");

	a_elastic_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[263:256] == 8'd0))
		else $error("iterations on elastic point");

endmodule

[sim/mrmp_checker.sv]
`timescale 1ns / 1ps

module mrmp_checker
	import mrmp_pkg::*;
#(
	parameter int FRAC_BITS = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	input  logic         pready,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [511:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [263:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           errors,
	output int           pending,
	output int           points_done,
	output int           yield_count,
	output int           limit_count
);

	typedef logic signed [63:0] fix_t;

	localparam fix_t FIX_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam fix_t FIX_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		logic [63:0] gam;
		logic [63:0] n0;
		logic [63:0] n1;
		logic [63:0] n2;
		logic        yielding;
		logic        unconv;
		logic [7:0]  iters;
	} point_result_t;

	logic [62:0] young_mod, shear_mod, yield0, hard_mod;
	logic        plast_en;
	logic [7:0]  iter_cap;

	point_result_t expected_results[$];

	function automatic logic [63:0] mag(fix_t a);
		return (a < 0) ? 64'(-a) : 64'(a);
	endfunction

	function automatic fix_t from_mag(bit neg, logic [127:0] m);
		if (neg) begin
			if (m >= (128'd1 << 63))
				return FIX_MIN;
			return -fix_t'(m[63:0]);
		end
		if (m > 128'(FIX_MAX))
			return FIX_MAX;
		return fix_t'(m[63:0]);
	endfunction

	function automatic fix_t sat_add(fix_t a, fix_t b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > 65'sd0 && s[64:63] == 2'b01)
			return FIX_MAX;
		if (s[64:63] == 2'b10)
			return FIX_MIN;
		return s[63:0];
	endfunction

	function automatic fix_t sat_sub(fix_t a, fix_t b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) - $signed({b[63], b});
		if (s[64:63] == 2'b01)
			return FIX_MAX;
		if (s[64:63] == 2'b10)
			return FIX_MIN;
		return s[63:0];
	endfunction

	function automatic fix_t fx_mul(fix_t a, fix_t b);
		logic [127:0] p;
		p = {64'b0, mag(a)} * {64'b0, mag(b)};
		return from_mag((a < 0) != (b < 0), p >> FRAC_BITS);
	endfunction

	function automatic fix_t fx_div(fix_t a, fix_t b);
		logic [127:0] n;
		if (b == 0)
			return (a > 0) ? FIX_MAX : ((a < 0) ? FIX_MIN : 64'sd0);
		n = {64'b0, mag(a)} << FRAC_BITS;
		return from_mag((a < 0) != (b < 0), n / {64'b0, mag(b)});
	endfunction

	function automatic fix_t triple(fix_t a);
		return sat_add(sat_add(a, a), a);
	endfunction

	function automatic logic [127:0] wide_add(logic [127:0] a, logic [127:0] b);
		logic [128:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[128] ? {128{1'b1}} : s[127:0];
	endfunction

	function automatic fix_t stress_norm(fix_t s0, fix_t s1, fix_t s2);
		logic [127:0] sum, t1, t2, cc;
		logic [63:0]  res, c;
		sum = {64'b0, mag(s0)} * {64'b0, mag(s0)};
		t1 = {64'b0, mag(s1)} * {64'b0, mag(s1)};
		t2 = {64'b0, mag(s2)} * {64'b0, mag(s2)};
		for (int k = 0; k < 3; k++)
			sum = wide_add(sum, t1);
		for (int k = 0; k < 3; k++)
			sum = wide_add(sum, t2);
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (64'd1 << b);
			cc = {64'b0, c} * {64'b0, c};
			if (cc <= sum)
				res = c;
		end
		return res[63] ? FIX_MAX : fix_t'(res);
	endfunction

	function automatic point_result_t return_map(in_t pt);
		fix_t et[3], st[3], cm[3], pc[3], nrm[3], bc[3];
		fix_t eqp0, hh, one, y0, gam, ftrial, eqp, sy, eqs, f, q, r1, r2, df, ng;
		logic [127:0] lhs;
		int iters, limit;
		bit unconv, yielding;
		point_result_t r;
		eqp0 = fix_t'({1'b0, pt.eqp});
		hh = fix_t'({1'b0, hard_mod});
		y0 = fix_t'({1'b0, yield0});
		one = fix_t'(64'd1 << FRAC_BITS);
		cm[0] = fix_t'({1'b0, young_mod});
		cm[1] = fix_t'({1'b0, shear_mod});
		cm[2] = cm[1];
		pc[0] = cm[0];
		pc[1] = triple(cm[1]);
		pc[2] = pc[1];
		et[0] = sat_sub($signed(pt.st0), $signed(pt.pl0));
		et[1] = sat_sub($signed(pt.st1), $signed(pt.pl1));
		et[2] = sat_sub($signed(pt.st2), $signed(pt.pl2));
		for (int i = 0; i < 3; i++)
			st[i] = fx_mul(cm[i], et[i]);
		ftrial = sat_sub(stress_norm(st[0], st[1], st[2]), sat_add(y0, fx_mul(hh, eqp0)));
		gam = 0;
		iters = 0;
		unconv = 0;
		yielding = 0;
		if (ftrial > 0 && plast_en) begin
			limit = (iter_cap == 0) ? 1 : int'(iter_cap);
			gam = $signed(pt.gstart);
			yielding = 1;
			do begin
				eqp = sat_add(eqp0, gam);
				sy = sat_add(y0, fx_mul(hh, eqp));
				for (int i = 0; i < 3; i++) begin
					bc[i] = fx_div(cm[i], sat_add(one, fx_div(fx_mul(pc[i], gam), sy)));
					st[i] = fx_mul(bc[i], et[i]);
				end
				eqs = stress_norm(st[0], st[1], st[2]);
				f = sat_sub(eqs, sy);
				for (int i = 0; i < 3; i++)
					nrm[i] = (eqs == 0) ? 64'sd0 : fx_div(i == 0 ? st[i] : triple(st[i]), eqs);
				q = 0;
				for (int i = 0; i < 3; i++)
					q = sat_add(q, fx_mul(bc[i], fx_mul(nrm[i], nrm[i])));
				r1 = fx_div(eqs, sy);
				r2 = sat_sub(one, fx_div(fx_mul(gam, hh), sy));
				df = sat_sub(0, sat_add(fx_mul(fx_mul(r1, r2), q), hh));
				ng = sat_sub(gam, fx_div(f, df));
				lhs = {64'b0, mag(sat_sub(ng, gam))} * {64'b0, TOL_INVERSE};
				unconv = lhs > {64'b0, mag(ng)};
				gam = ng;
				iters++;
			end while (unconv && iters < limit);
		end
		eqs = stress_norm(st[0], st[1], st[2]);
		for (int i = 0; i < 3; i++)
			nrm[i] = (eqs == 0) ? 64'sd0 : fx_div(i == 0 ? st[i] : triple(st[i]), eqs);
		r.gam = gam;
		r.n0 = nrm[0];
		r.n1 = nrm[1];
		r.n2 = nrm[2];
		r.yielding = yielding;
		r.unconv = unconv;
		r.iters = iters[7:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			young_mod <= 63'd219902325555200000;
			shear_mod <= 63'd87960930222080000;
			yield0 <= 63'd274877906944000;
			hard_mod <= '0;
			plast_en <= 1'b1;
			iter_cap <= 8'd100;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[5:3])
				REG_YOUNG: young_mod <= pwdata[62:0];
				REG_SHEAR: shear_mod <= pwdata[62:0];
				REG_YIELD: yield0 <= pwdata[62:0];
				REG_HARD:  hard_mod <= pwdata[62:0];
				REG_PLAST: plast_en <= pwdata[0];
				REG_MAXIT: iter_cap <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	initial begin
		errors = 0;
		points_done = 0;
		yield_count = 0;
		limit_count = 0;
	end

	assign pending = expected_results.size();

	always @(posedge clk) begin
		point_result_t exp_r, act_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				act_r.gam = m_tdata[63:0];
				act_r.n0 = m_tdata[127:64];
				act_r.n1 = m_tdata[191:128];
				act_r.n2 = m_tdata[255:192];
				act_r.iters = m_tdata[263:256];
				act_r.yielding = m_tuser[0];
				act_r.unconv = m_tuser[1];
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat: gamma %h", act_r.gam);
				end else begin
					exp_r = expected_results.pop_front();
					points_done++;
					yield_count += exp_r.yielding;
					limit_count += exp_r.unconv;
					if (act_r.gam !== exp_r.gam || act_r.n0 !== exp_r.n0 ||
					    act_r.n1 !== exp_r.n1 || act_r.n2 !== exp_r.n2 ||
					    act_r.yielding !== exp_r.yielding ||
					    act_r.unconv !== exp_r.unconv || act_r.iters !== exp_r.iters) begin
						errors++;
						if (errors <= 10) begin
							$display("point %0d mismatch: gamma exp %h got %h, n exp %h %h %h",
								points_done, exp_r.gam, act_r.gam, exp_r.n0, exp_r.n1, exp_r.n2);
							$display("  n got %h %h %h, yld/unc/it exp %b %b %0d got %b %b %0d",
								act_r.n0, act_r.n1, act_r.n2, exp_r.yielding, exp_r.unconv,
								exp_r.iters, act_r.yielding, act_r.unconv, act_r.iters);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(return_map(in_t'(s_tdata[510:0])));
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import mrmp_pkg::*;

	typedef logic signed [63:0] fix_t;

	localparam int   WATCHDOG_LIMIT = 2500000;
	localparam fix_t FIX_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam fix_t FIX_MIN = 64'sh8000_0000_0000_0000;
	localparam logic [62:0] E_DEF = 63'd219902325555200000;
	localparam logic [62:0] G_DEF = 63'd87960930222080000;
	localparam logic [62:0] Y_DEF = 63'd274877906944000;
	localparam logic [62:0] MAX63 = {63{1'b1}};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [5:0]   paddr = '0;
	logic [63:0]  pwdata = '0;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// strain_axial, strain_shear_y, strain_shear_z, plastic_axial, plastic_shear_y,
	// plastic_shear_z, equivalent_plastic (63), gamma_start, one zero pad bit
	logic [511:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// gamma_out, normal_axial, normal_shear_y, normal_shear_z, iterations_used
	logic [263:0] m_tdata;
	// is_yielding, not_converged
	logic [1:0]   m_tuser;

	int errors, pending, points_done, yield_count, limit_count;
	int idle_cycles = 0;
	int sink_stall = 0;
	bit sink_steady = 0;
	bit source_steady = 0;
	int phases = 0;

	always #5 clk = ~clk;

	mises_return_mapping_point dut (.*);

	mrmp_checker u_checker (.*);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 399) == 0)
			sink_steady <= !sink_steady;
		if (sink_stall > 0) begin
			m_tready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else begin
			m_tready <= 1'b1;
			if (!sink_steady && $urandom_range(0, 9) < 3)
				sink_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
				                                         : $urandom_range(1, 4);
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (source_steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	function automatic fix_t wild_value();
		case ($urandom_range(0, 5))
			0: return 64'sd0;
			1: return FIX_MAX;
			2: return FIX_MIN;
			3: return 64'sd1;
			4: return -64'sd1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_t make_point(int wild_pct);
		in_t pt;
		fix_t w;
		if ($urandom_range(0, 99) < wild_pct) begin
			pt.st0 = wild_value();
			pt.st1 = wild_value();
			pt.st2 = wild_value();
			pt.pl0 = wild_value();
			pt.pl1 = wild_value();
			pt.pl2 = wild_value();
			w = wild_value();
			pt.eqp = w[62:0];
			pt.gstart = wild_value();
		end else begin
			pt.st0 = fix_t'($signed($urandom));
			pt.st1 = fix_t'($signed($urandom)) >>> 1;
			pt.st2 = fix_t'($signed($urandom)) >>> 1;
			pt.pl0 = fix_t'($signed($urandom)) >>> 2;
			pt.pl1 = fix_t'($signed($urandom)) >>> 3;
			pt.pl2 = fix_t'($signed($urandom)) >>> 3;
			pt.eqp = {31'b0, $urandom};
			pt.gstart = ($urandom_range(0, 3) == 0) ? fix_t'($urandom_range(0, 1 << 20)) : 64'sd0;
		end
		return pt;
	endfunction

	function automatic in_t point_of(fix_t e0, fix_t e1, fix_t e2, fix_t p0, fix_t p1,
			fix_t p2, logic [62:0] eqp, fix_t g);
		in_t pt;
		pt.st0 = e0;
		pt.st1 = e1;
		pt.st2 = e2;
		pt.pl0 = p0;
		pt.pl1 = p1;
		pt.pl2 = p2;
		pt.eqp = eqp;
		pt.gstart = g;
		return pt;
	endfunction

	// call at a falling edge; returns at a falling edge
	task automatic send_point(input in_t pt);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, pt};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_material(input logic [62:0] e, g, y, h, input logic plast,
			input logic [7:0] max_it);
		drain();
		reg_write(REG_YOUNG, {1'b0, e});
		reg_write(REG_SHEAR, {1'b0, g});
		reg_write(REG_YIELD, {1'b0, y});
		reg_write(REG_HARD, {1'b0, h});
		reg_write(REG_PLAST, {63'b0, plast});
		reg_write(REG_MAXIT, {56'b0, max_it});
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		source_steady = ($urandom_range(0, 3) == 0);
		phases++;
		@(negedge clk);
	endtask

	task automatic send_random(input int count, input int wild_pct);
		repeat (count) send_point(make_point(wild_pct));
	endtask

	initial begin
		logic [63:0] r;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults out of reset: zero stress, then a point that yields
		send_point(point_of(0, 0, 0, 0, 0, 0, 0, 0));
		send_point(point_of(64'sd2147483648, 64'sd100000000, 0, 0, 0, 0, 0, 0));

		set_material(E_DEF, G_DEF, Y_DEF, 63'd0, 1'b1, 8'd3);
		send_point(point_of(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, MAX63, FIX_MAX));
		send_point(point_of(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 0, FIX_MIN));
		send_point(point_of(FIX_MAX, 0, 0, FIX_MIN, 0, 0, 0, 0));
		send_point(point_of(64'sd12345678, -64'sd555, 64'sd77, 64'sd12345678, -64'sd555,
			64'sd77, 63'd1000, 0));
		send_point(point_of(64'sd100000, 64'sd20000, -64'sd30000, 0, 0, 0, 0, 0));
		send_point(point_of(-64'sd3000000000, 0, 0, 0, 0, 0, 63'd50000, 0));
		send_point(point_of(0, 64'sd2000000000, -64'sd2000000000, 0, 0, 0, 0, 64'sd1000));
		send_point(point_of(64'sd1500000000, 64'sd500000000, 64'sd500000000, 64'sd10000000,
			0, 0, MAX63, 64'sd4096));
		send_point(point_of(64'sd4000000000, 0, 0, 0, 0, 0, 0, FIX_MAX));
		send_point(point_of(64'sd4000000000, 0, 0, 0, 0, 0, 0, -64'sd1));
		send_point(point_of(-64'sd1, 64'sd1, -64'sd1, 64'sd1, -64'sd1, 64'sd1, 63'd1, 64'sd1));
		send_point(point_of(FIX_MAX, FIX_MIN, FIX_MAX, 0, 0, 0, 0, 0));

		r = {$urandom, $urandom};
		set_material(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
			63'({$urandom, $urandom}), r[62:0], 1'b0, 8'($urandom));
		send_random(60, 50);

		set_material(MAX63, 63'd1, 63'd1, MAX63, 1'b1, 8'd1);
		send_random(40, 50);

		r = 64'd1 << 50;
		set_material(E_DEF, G_DEF, Y_DEF, r[62:0] + 63'($urandom), 1'b1, 8'd2);
		send_random(60, 10);

		set_material(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
			63'({$urandom, $urandom}), 63'd0, 1'b1, 8'd0);
		send_random(30, 30);

		set_material(63'd1, 63'd1, MAX63, 63'd0, 1'b1, 8'd3);
		send_random(40, 50);

		set_material(E_DEF, G_DEF, Y_DEF, r[62:0], 1'b1, 8'd255);
		send_random(2, 0);

		set_material(E_DEF, G_DEF, Y_DEF, 63'd0, 1'b1, 8'd4);
		send_random(40, 20);

		drain();
		repeat (100) @(posedge clk);
		$display("Checked %0d points over %0d register settings plus reset defaults.",
			points_done, phases);
		$display("%0d points took the plastic return, %0d stopped at the iteration cap.",
			yield_count, limit_count);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[mises_return_mapping_point.f]
src/mrmp_pkg.sv
src/mrmp_ctrl.sv
src/mrmp_dpath.sv
src/mises_return_mapping_point.sv
sim/mrmp_checker.sv
sim/testbench.sv
